### sv/ttse_pkg.sv
// Shared types and constants for the terminal tab stop engine.
// Used by the controller, the datapath and the top level; depends on nothing.
package ttse_pkg;

    // Sizes of the line and of the payload fields.
    localparam int MAX_COLUMNS = 256;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int WIDTH_W     = COL_W + 1;
    localparam int COUNT_W     = 16;
    localparam int OP_W        = 3;

    // Default stops fall on every eighth column.
    localparam int TAB_LOG2 = 3;

    // Line width after reset.
    localparam logic [WIDTH_W-1:0] LINE_WIDTH_RESET = WIDTH_W'(80);

    // Operation codes.
    localparam logic [OP_W-1:0] OP_SET_STOP   = 3'd0;
    localparam logic [OP_W-1:0] OP_CLEAR_STOP = 3'd1;
    localparam logic [OP_W-1:0] OP_CLEAR_ALL  = 3'd2;
    localparam logic [OP_W-1:0] OP_DEFAULTS   = 3'd3;
    localparam logic [OP_W-1:0] OP_FORWARD    = 3'd4;
    localparam logic [OP_W-1:0] OP_BACKWARD   = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the input beat
        logic ext_step;    // initialize one more column of the bitmap
        logic clear_all;   // empty the bitmap and drop the defaults
        logic defaults;    // empty the bitmap and restore the defaults
        logic write_stop;  // set or clear the stop under the cursor
        logic set_fault;   // flag the cursor as outside the line
        logic scan_issue;  // read the next column in the direction of movement
        logic scan_test;   // step onto that column and count its stop
        logic out_load;    // move the result into the output register
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            need_extend;
        logic            cursor_out;
        logic            scan_more;
        logic            out_free;
    } dp_status_t;

endpackage

### sv/ttse_ctrl.sv
// Controller state machine of the terminal tab stop engine.
// Depends on ttse_pkg; drives the command struct of ttse_datapath.
module ttse_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  ttse_pkg::dp_status_t  status,
    output ttse_pkg::ctrl_cmd_t   cmd
);
    import ttse_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_EXTEND = 6'b000010,
        ST_EXEC   = 6'b000100,
        ST_ISSUE  = 6'b001000,
        ST_TEST   = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXTEND;
                end
            end
            ST_EXTEND: begin
                // Only column operations extend the bitmap first.
                if (status.need_extend &&
                    (status.op == OP_SET_STOP || status.op == OP_CLEAR_STOP ||
                     status.op == OP_FORWARD || status.op == OP_BACKWARD)) begin
                    cmd.ext_step = 1'b1;
                end else begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_FINISH;
                case (status.op)
                    OP_SET_STOP, OP_CLEAR_STOP: begin
                        if (status.cursor_out) begin
                            cmd.set_fault = 1'b1;
                        end else begin
                            cmd.write_stop = 1'b1;
                        end
                    end
                    OP_FORWARD, OP_BACKWARD: begin
                        if (status.cursor_out) begin
                            cmd.set_fault = 1'b1;
                        end else begin
                            state_next = ST_ISSUE;
                        end
                    end
                    OP_CLEAR_ALL: begin
                        cmd.clear_all = 1'b1;
                    end
                    OP_DEFAULTS: begin
                        cmd.defaults = 1'b1;
                    end
                    default: begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_ISSUE: begin
                if (status.scan_more) begin
                    cmd.scan_issue = 1'b1;
                    state_next     = ST_TEST;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_TEST: begin
                cmd.scan_test = 1'b1;
                state_next    = ST_ISSUE;
            end
            ST_FINISH: begin
                // Wait until the output register is free.
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    // A test step always follows the read that feeds it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_test |-> $past(cmd.scan_issue))
        else $error("scan test without a preceding read");

    // A new beat is only taken while the controller is idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> (state_reg == ST_IDLE))
        else $error("input beat taken while busy");

    // The state register always holds exactly one state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("state register not one-hot");
`endif

endmodule

### sv/ttse_datapath.sv
// Datapath of the terminal tab stop engine: stop bitmap memory, cursor,
// counters, line width register and output register. Depends on ttse_pkg.
module ttse_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [ttse_pkg::OP_W-1:0]     s_operation,
    input  logic [ttse_pkg::COL_W-1:0]    s_cursor_column,
    input  logic [ttse_pkg::COUNT_W-1:0]  s_tab_count,
    input  logic                          cfg_valid,
    input  logic [ttse_pkg::WIDTH_W-1:0]  cfg_wdata,
    input  ttse_pkg::ctrl_cmd_t           cmd,
    output ttse_pkg::dp_status_t          status,
    input  logic                          m_ready,
    output logic                          m_valid,
    output logic [ttse_pkg::COL_W-1:0]    m_new_column,
    output logic                          m_fault
);
    import ttse_pkg::*;

    logic [WIDTH_W-1:0] line_width_reg;
    logic [WIDTH_W-1:0] init_width_reg;
    logic               dflt_reg;
    logic [OP_W-1:0]    op_reg;
    logic [COL_W-1:0]   cur_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COL_W-1:0]   col_reg;
    logic [COUNT_W-1:0] done_reg;
    logic               fault_reg;
    logic [COL_W-1:0]   addr_reg;
    logic               rd_data_reg;
    logic               m_valid_reg;
    logic [COL_W-1:0]   m_col_reg;
    logic               m_fault_reg;

    logic [WIDTH_W-1:0] eff_width;
    logic [COL_W-1:0]   scan_addr;
    logic               fwd;
    logic               wr_en;
    logic [COL_W-1:0]   wr_addr;
    logic               wr_data;

    logic mem [MAX_COLUMNS];

    // Widths above the line buffer saturate.
    assign eff_width = (line_width_reg > WIDTH_W'(MAX_COLUMNS)) ?
                       WIDTH_W'(MAX_COLUMNS) : line_width_reg;

    assign fwd = (op_reg == OP_FORWARD);

    // Neighbor column in the direction of movement.
    assign scan_addr = fwd ? (col_reg + COL_W'(1)) : (col_reg - COL_W'(1));

    // Status toward the controller.
    always_comb begin
        status.op          = op_reg;
        status.need_extend = (init_width_reg < eff_width);
        status.cursor_out  = ({1'b0, cur_reg} >= eff_width);
        if (fwd) begin
            status.scan_more = (({1'b0, col_reg} + WIDTH_W'(1)) < eff_width) &&
                               (done_reg < count_reg);
        end else begin
            status.scan_more = (col_reg != '0) && (done_reg < count_reg);
        end
        status.out_free = !m_valid_reg || m_ready;
    end

    // Line width register, written from the configuration port.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg <= LINE_WIDTH_RESET;
        end else if (cfg_valid) begin
            line_width_reg <= cfg_wdata;
        end
    end

    // Initialized width and default flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_width_reg <= '0;
            dflt_reg       <= 1'b1;
        end else if (cmd.clear_all) begin
            init_width_reg <= '0;
            dflt_reg       <= 1'b0;
        end else if (cmd.defaults) begin
            init_width_reg <= '0;
            dflt_reg       <= 1'b1;
        end else if (cmd.ext_step) begin
            init_width_reg <= init_width_reg + WIDTH_W'(1);
        end
    end

    // Captured command, cursor and scan counters.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= s_operation;
            cur_reg   <= s_cursor_column;
            count_reg <= s_tab_count;
            col_reg   <= s_cursor_column;
            done_reg  <= '0;
            fault_reg <= 1'b0;
        end else begin
            if (cmd.set_fault) begin
                fault_reg <= 1'b1;
            end
            if (cmd.scan_test) begin
                col_reg <= addr_reg;
                if (rd_data_reg) begin
                    done_reg <= done_reg + COUNT_W'(1);
                end
            end
        end
    end

    // Single write port: extension fill or the stop under the cursor.
    always_comb begin
        wr_en   = cmd.ext_step || cmd.write_stop;
        wr_addr = cmd.ext_step ? init_width_reg[COL_W-1:0] : cur_reg;
        if (cmd.ext_step) begin
            wr_data = dflt_reg && (init_width_reg[COL_W-1:TAB_LOG2] != '0) &&
                      (init_width_reg[TAB_LOG2-1:0] == '0);
        end else begin
            wr_data = (op_reg == OP_SET_STOP);
        end
    end

    // Stop bitmap memory with a registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[scan_addr];
        if (cmd.scan_issue) begin
            addr_reg <= scan_addr;
        end
    end

    // Output register; holds its beat until the receiver takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_col_reg   <= col_reg;
            m_fault_reg <= fault_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_new_column = m_col_reg;
    assign m_fault      = m_fault_reg;

`ifndef SYNTH
    // The initialized part of the bitmap never outgrows the buffer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        init_width_reg <= WIDTH_W'(MAX_COLUMNS))
        else $error("initialized width beyond the buffer");

    // A result is never loaded over one that is still waiting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("output register overwritten");

    // Stops are only written inside the line.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.write_stop |-> ({1'b0, cur_reg} < eff_width))
        else $error("stop written outside the line");
`endif

endmodule

### sv/terminal_tab_stop_engine.sv
// Top level of the terminal tab stop engine.
// Depends on ttse_pkg, ttse_ctrl and ttse_datapath.
//
// Input channel (s_): one beat carries an operation, the cursor column and
// a tab count. Result channel (m_): one beat per input beat, carrying the
// new cursor column and a fault flag. Configuration channel (cfg_): one
// beat writes the line width; cfg_ready is always high, and writes belong
// between commands.
//
// The bitmap is extended by up to 256 columns, one per cycle through the
// single write port of the stop memory, and a forward or backward move
// walks over up to 255 columns, each read and then tested in its own state
// (ST_ISSUE, then ST_TEST) because the memory read is registered. One item
// is worked on at a time; s_ready is high while the controller is idle.
//
// Reset: line width 80, bitmap empty, default stops enabled; no result is
// pending. If the receiver stalls, the result stays in the output register
// and the next input beat is still taken; that item finishes its work and
// then waits until the output register is free.
module terminal_tab_stop_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ttse_pkg::OP_W-1:0]     s_operation,
    input  logic [ttse_pkg::COL_W-1:0]    s_cursor_column,
    input  logic [ttse_pkg::COUNT_W-1:0]  s_tab_count,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ttse_pkg::COL_W-1:0]    m_new_column,
    output logic                          m_fault,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ttse_pkg::WIDTH_W-1:0]  cfg_wdata
);
    import ttse_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // The width register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    ttse_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ttse_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_operation     (s_operation),
        .s_cursor_column (s_cursor_column),
        .s_tab_count     (s_tab_count),
        .cfg_valid       (cfg_valid),
        .cfg_wdata       (cfg_wdata),
        .cmd             (cmd),
        .status          (status),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_new_column    (m_new_column),
        .m_fault         (m_fault)
    );

endmodule

### dv/ttse_checker.sv
`timescale 1ns / 100ps
// Checker for the terminal tab stop engine: follows the input, result and line width beats,
// keeps its own tab stop bitmap and compares every result beat with the oldest prediction.
// Depends on ttse_pkg.
module ttse_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [ttse_pkg::OP_W-1:0]     s_operation,
    input  logic [ttse_pkg::COL_W-1:0]    s_cursor_column,
    input  logic [ttse_pkg::COUNT_W-1:0]  s_tab_count,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [ttse_pkg::COL_W-1:0]    m_new_column,
    input  logic                          m_fault,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [ttse_pkg::WIDTH_W-1:0]  cfg_wdata,
    output int                            mismatches,
    output int                            outstanding
);
    import ttse_pkg::*;

    localparam int TAB_SPACING = 1 << TAB_LOG2;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic             fault;
    } cursor_beat_t;

    // Predicted result beats, oldest first.
    cursor_beat_t cursor_q[$];

    // Shadow copy of the engine state.
    bit                 stop_map [MAX_COLUMNS];
    int unsigned        ready_cols;
    bit                 default_stops;
    logic [WIDTH_W-1:0] line_width;

    int errors = 0;

    assign mismatches = errors;

    task automatic report_mismatch(input string what);
        $display("%0t: tab stop mismatch: %s", $time, what);
        errors++;
    endtask

    // Line width as the engine uses it, saturated to the bitmap size.
    function automatic int unsigned line_columns();
        int unsigned w;
        w = 32'(line_width);
        return (w > MAX_COLUMNS) ? MAX_COLUMNS : w;
    endfunction

    // Bring the bitmap up to the given width, placing default stops if they are enabled.
    function automatic void cover_columns(input int unsigned w);
        for (int unsigned c = ready_cols; c < w; c++) begin
            stop_map[c] = default_stops && (c >= TAB_SPACING) && (c % TAB_SPACING == 0);
        end
        if (w > ready_cols) begin
            ready_cols = w;
        end
    endfunction

    // Apply one command to the shadow state and return the result beat it causes.
    function automatic cursor_beat_t apply_command(input logic [OP_W-1:0] op,
                                                   input logic [COL_W-1:0] cursor,
                                                   input logic [COUNT_W-1:0] count);
        int unsigned  w;
        int unsigned  col;
        int unsigned  hops;
        cursor_beat_t beat;
        w          = line_columns();
        col        = 32'(cursor);
        hops       = 0;
        beat.fault = 1'b0;
        case (op)
            OP_SET_STOP, OP_CLEAR_STOP, OP_FORWARD, OP_BACKWARD: begin
                cover_columns(w);
                if (cursor >= w) begin
                    beat.fault = 1'b1;
                end else if (op == OP_SET_STOP) begin
                    stop_map[cursor] = 1'b1;
                end else if (op == OP_CLEAR_STOP) begin
                    stop_map[cursor] = 1'b0;
                end else if (op == OP_FORWARD) begin
                    while (col + 1 < w && hops < count) begin
                        col++;
                        if (stop_map[col]) hops++;
                    end
                end else begin
                    while (col > 0 && hops < count) begin
                        col--;
                        if (stop_map[col]) hops++;
                    end
                end
            end
            OP_CLEAR_ALL: begin
                ready_cols    = 0;
                default_stops = 1'b0;
            end
            OP_DEFAULTS: begin
                ready_cols    = 0;
                default_stops = 1'b1;
            end
            default: begin
            end
        endcase
        beat.column = col[COL_W-1:0];
        return beat;
    endfunction

    // Watch all three channels at each rising edge.
    always @(posedge aclk) begin : watch
        cursor_beat_t want;
        if (!aresetn) begin
            ready_cols    = 0;
            default_stops = 1'b1;
            line_width    = LINE_WIDTH_RESET;
            cursor_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                line_width = cfg_wdata;
            end
            // A result beat is matched against the oldest prediction.
            if (m_valid && m_ready) begin
                if (cursor_q.size() == 0) begin
                    report_mismatch($sformatf("result column %0d fault %0d with none pending",
                                              m_new_column, m_fault));
                end else begin
                    want = cursor_q.pop_front();
                    if (m_new_column !== want.column) begin
                        report_mismatch($sformatf("new_column %0d, predicted %0d",
                                                  m_new_column, want.column));
                    end
                    if (m_fault !== want.fault) begin
                        report_mismatch($sformatf("fault %0d, predicted %0d",
                                                  m_fault, want.fault));
                    end
                end
            end
            // Each input beat adds one prediction.
            if (s_valid && s_ready) begin
                cursor_q.push_back(apply_command(s_operation, s_cursor_column, s_tab_count));
            end
        end
        outstanding <= cursor_q.size();
    end

endmodule

### dv/terminal_tab_stop_engine_tb.sv
`timescale 1ns / 100ps
// Testbench top for the terminal tab stop engine: clock, reset, command and line width
// stimulus, a stalling receiver and the verdict. Depends on ttse_pkg, ttse_checker and the RTL.
module terminal_tab_stop_engine_tb;
    import ttse_pkg::*;

    // Codes that the engine ignores.
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    localparam int NUM_PHASES      = 9;
    localparam int ITEMS_PER_PHASE = 45;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [OP_W-1:0]    s_operation;
    logic [COL_W-1:0]   s_cursor_column;
    logic [COUNT_W-1:0] s_tab_count;
    logic               m_valid;
    logic               m_ready;
    logic [COL_W-1:0]   m_new_column;
    logic               m_fault;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [WIDTH_W-1:0] cfg_wdata;

    int mismatches;
    int outstanding;
    bit calm = 1'b0;

    terminal_tab_stop_engine dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_cursor_column (s_cursor_column),
        .s_tab_count     (s_tab_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_new_column    (m_new_column),
        .m_fault         (m_fault),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_wdata       (cfg_wdata)
    );

    ttse_checker tab_watch (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_cursor_column (s_cursor_column),
        .s_tab_count     (s_tab_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_new_column    (m_new_column),
        .m_fault         (m_fault),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_wdata       (cfg_wdata),
        .mismatches      (mismatches),
        .outstanding     (outstanding)
    );

    // Free-running 100 MHz clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Line width for each random phase: extremes, saturation, shrink and regrowth.
    function automatic logic [WIDTH_W-1:0] phase_width(input int p);
        case (p)
            0:       return WIDTH_W'(0);
            1:       return WIDTH_W'(511);
            2:       return WIDTH_W'(1);
            3:       return WIDTH_W'(40);
            4:       return WIDTH_W'(256);
            5:       return WIDTH_W'(17);
            6:       return WIDTH_W'(300);
            7:       return WIDTH_W'(120);
            default: return WIDTH_W'(80);
        endcase
    endfunction

    // Offer one command beat after a random gap and hold it until it is taken.
    task automatic send_command(input logic [OP_W-1:0] op, input logic [COL_W-1:0] cursor,
                                input logic [COUNT_W-1:0] count);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_operation     <= op;
        s_cursor_column <= cursor;
        s_tab_count     <= count;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Stop sending and wait until every predicted result beat has arrived.
    task automatic wait_quiet();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic write_width(input logic [WIDTH_W-1:0] w);
        cfg_valid <= 1'b1;
        cfg_wdata <= w;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly moves and stop edits with cursors inside the line; some wholesale resets,
    // ignored codes and cursors anywhere.
    task automatic random_command(input int cols);
        int                 pick;
        int                 dice;
        logic [OP_W-1:0]    op;
        logic [COL_W-1:0]   cursor;
        logic [COUNT_W-1:0] count;
        pick = $urandom_range(0, 99);
        if (pick < 30)      op = OP_FORWARD;
        else if (pick < 55) op = OP_BACKWARD;
        else if (pick < 72) op = OP_SET_STOP;
        else if (pick < 86) op = OP_CLEAR_STOP;
        else if (pick < 91) op = OP_CLEAR_ALL;
        else if (pick < 96) op = OP_DEFAULTS;
        else if (pick < 98) op = OP_SPARE_6;
        else                op = OP_SPARE_7;
        if (cols > 0 && $urandom_range(0, 9) != 0) begin
            cursor = COL_W'($urandom_range(0, cols - 1));
        end else begin
            cursor = COL_W'($urandom_range(0, 255));
        end
        dice = $urandom_range(0, 99);
        if (dice < 70)      count = COUNT_W'($urandom_range(0, 4));
        else if (dice < 85) count = COUNT_W'($urandom_range(5, 40));
        else if (dice < 97) count = COUNT_W'($urandom_range(0, 65535));
        else                count = '1;
        send_command(op, cursor, count);
    endtask

    // Receiver: stalls a random number of cycles before each result beat.
    initial begin : receiver
        int stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // Stimulus and verdict.
    initial begin : stimulus
        int cols;
        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_operation     <= OP_SET_STOP;
        s_cursor_column <= '0;
        s_tab_count     <= '0;
        cfg_valid       <= 1'b0;
        cfg_wdata       <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed commands at the reset width of 80 with default stops.
        send_command(OP_FORWARD,    8'd0,   16'd1);
        send_command(OP_FORWARD,    8'd0,   16'd0);
        send_command(OP_FORWARD,    8'd0,   16'hFFFF);
        send_command(OP_BACKWARD,   8'd79,  16'd2);
        send_command(OP_BACKWARD,   8'd0,   16'd1);
        send_command(OP_BACKWARD,   8'd79,  16'hFFFF);
        send_command(OP_SET_STOP,   8'd0,   16'd0);
        send_command(OP_SET_STOP,   8'd79,  16'd0);
        send_command(OP_FORWARD,    8'd72,  16'd1);
        send_command(OP_CLEAR_STOP, 8'd8,   16'd0);
        send_command(OP_FORWARD,    8'd0,   16'd1);
        // Cursors at or beyond the line edge.
        send_command(OP_SET_STOP,   8'd255, 16'd0);
        send_command(OP_FORWARD,    8'd80,  16'd1);
        send_command(OP_BACKWARD,   8'd200, 16'd3);
        send_command(OP_CLEAR_STOP, 8'd170, 16'd0);
        // Ignored codes.
        send_command(OP_SPARE_6,    8'd85,  16'h5555);
        send_command(OP_SPARE_7,    8'd255, 16'hFFFF);
        // Clearing everything, then restoring the defaults.
        send_command(OP_CLEAR_ALL,  8'd3,   16'd0);
        send_command(OP_FORWARD,    8'd0,   16'd3);
        send_command(OP_SET_STOP,   8'd40,  16'd0);
        send_command(OP_BACKWARD,   8'd79,  16'd1);
        send_command(OP_DEFAULTS,   8'd77,  16'd0);
        send_command(OP_FORWARD,    8'd8,   16'hAAAA);
        send_command(OP_BACKWARD,   8'd15,  16'h5555);

        // Random phases, one line width each; the middle of each phase drains fully.
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_quiet();
            write_width(phase_width(p));
            calm = (p % 3 == 1);
            cols = (phase_width(p) > MAX_COLUMNS) ? MAX_COLUMNS : int'(phase_width(p));
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (i == ITEMS_PER_PHASE / 2) begin
                    wait_quiet();
                end
                random_command(cols);
            end
        end

        // Drain, then leave room for any stray result beat.
        wait_quiet();
        repeat (800) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Hard limit on the run length.
    initial begin
        #12_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

### files.f
sv/ttse_pkg.sv
sv/ttse_ctrl.sv
sv/ttse_datapath.sv
sv/terminal_tab_stop_engine.sv
dv/ttse_checker.sv
dv/terminal_tab_stop_engine_tb.sv
